@@ rtl/prp_pkg.sv @@
// ----------------------------------------------------------------------------
// prp_pkg
// Shared constants and types for the pairwise repulsion pass.
// ----------------------------------------------------------------------------
package prp_pkg;

   localparam int MAX_ENTITIES = 64;
   localparam int IDX_W        = 6;
   localparam int CNT_W        = 7;
   localparam int POS_W        = 24;
   localparam int SUM_W        = 40;

   // register word indices, matched against paddr[4:2]
   localparam logic [2:0] REG_SEP_RADIUS = 3'd0;
   localparam logic [2:0] REG_FORCE_GAIN = 3'd1;
   localparam logic [2:0] REG_TIME_STEP  = 3'd2;
   localparam logic [2:0] REG_X_LIMIT    = 3'd3;
   localparam logic [2:0] REG_Y_LIMIT    = 3'd4;

   // arithmetic unit operations
   localparam logic [1:0] MODE_MUL  = 2'd0;
   localparam logic [1:0] MODE_DIV  = 2'd1;
   localparam logic [1:0] MODE_SQRT = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] mode;
      logic [5:0] count;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

endpackage

@@ rtl/prp_unit.sv @@
// ----------------------------------------------------------------------------
// prp_unit
// Shared bit-serial unit: shift-add multiply, restoring divide (32 quotient
// bits) and digit-by-digit square root, one step per cycle.
// ----------------------------------------------------------------------------
module prp_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  prp_pkg::unit_cmd_type cmd,
   input  logic [39:0]           opnd_a,
   input  logic [63:0]           opnd_b,
   output prp_pkg::unit_sts_type sts,
   output logic [63:0]           result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [39:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [27:0] rem_ff, rem_in;

   logic [63:0] mul_sum;
   logic [27:0] r2;
   logic [27:0] sub_rhs;
   logic [28:0] diff;
   logic        ge;

   always_comb begin
      mul_sum = {acc_ff[62:0], 1'b0} + (b_ff[63] ? {24'd0, a_ff} : 64'd0);
      if (mode_ff == prp_pkg::MODE_DIV) begin
         r2      = {2'd0, rem_ff[24:0], b_ff[63]};
         sub_rhs = {3'd0, a_ff[24:0]};
      end else begin
         r2      = {rem_ff[25:0], b_ff[63:62]};
         sub_rhs = {1'b0, acc_ff[24:0], 2'b01};
      end
      diff = {1'b0, r2} - {1'b0, sub_rhs};
      ge   = ~diff[28];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         cnt_in  = cmd.count;
         a_in    = opnd_a;
         acc_in  = 64'd0;
         if (cmd.mode == prp_pkg::MODE_DIV) begin
            // numerator >> 32 is below the divisor, so 32 steps suffice
            rem_in = {3'd0, opnd_b[56:32]};
            b_in   = {opnd_b[31:0], 32'd0};
         end else begin
            rem_in = 28'd0;
            b_in   = opnd_b;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (mode_ff)
            prp_pkg::MODE_MUL: begin
               acc_in = mul_sum;
               b_in   = {b_ff[62:0], 1'b0};
            end
            prp_pkg::MODE_DIV: begin
               acc_in = {acc_ff[62:0], ge};
               rem_in = ge ? diff[27:0] : r2;
               b_in   = {b_ff[62:0], 1'b0};
            end
            default: begin
               acc_in = {acc_ff[62:0], ge};
               rem_in = ge ? diff[27:0] : r2;
               b_in   = {b_ff[61:0], 2'b00};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
   end

   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

@@ rtl/pairwise_repulsion_pass.sv @@
// ----------------------------------------------------------------------------
// pairwise_repulsion_pass
// Loads a set of bodies, runs a soft-sphere repulsion pass in place and
// streams every body back out in slot order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  body_x, body_y, body_alive, load_last
//  rsp      out  rsp_valid/rsp_stall  body_index, new_x, new_y, is_alive,
//                                     result_last
//  csr      in   apb psel/penable     sep_radius, force_gain, time_step,
//                                     x_limit, y_limit
//
//  the load_last body starts the pass: square the radius, then per live body
//  skip dead partners, drop live pairs outside the radius or coincident, run
//  the full force step for pairs inside it, then move the body; results go
//  out one at a time, each held while rsp_stall is high; req_stall stays high
//  from the load_last transfer until the last result
//  reset is synchronous; body storage is not cleared
// ----------------------------------------------------------------------------
module pairwise_repulsion_pass (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_body_x,
   input  logic [23:0] req_body_y,
   input  logic        req_body_alive,
   input  logic        req_load_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_body_index,
   output logic [23:0] rsp_new_x,
   output logic [23:0] rsp_new_y,
   output logic        rsp_is_alive,
   output logic        rsp_result_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_SQ   = 5'd1;
   localparam logic [4:0] S_RDI  = 5'd2;
   localparam logic [4:0] S_LDI  = 5'd3;
   localparam logic [4:0] S_RDJ  = 5'd4;
   localparam logic [4:0] S_LDJ  = 5'd5;
   localparam logic [4:0] S_MXX  = 5'd6;
   localparam logic [4:0] S_MYY  = 5'd7;
   localparam logic [4:0] S_SQRT = 5'd8;
   localparam logic [4:0] S_MP   = 5'd9;
   localparam logic [4:0] S_DF   = 5'd10;
   localparam logic [4:0] S_MCX  = 5'd11;
   localparam logic [4:0] S_DCX  = 5'd12;
   localparam logic [4:0] S_MCY  = 5'd13;
   localparam logic [4:0] S_DCY  = 5'd14;
   localparam logic [4:0] S_MVX  = 5'd15;
   localparam logic [4:0] S_MVY  = 5'd16;
   localparam logic [4:0] S_WR   = 5'd17;
   localparam logic [4:0] S_EMRD = 5'd18;
   localparam logic [4:0] S_EMLD = 5'd19;
   localparam logic [4:0] S_EMOUT = 5'd20;

   localparam int MEM_W = 2 * prp_pkg::POS_W + 1;

   // configuration
   logic [23:0] sep_ff, gain_ff, width_ff, height_ff;
   logic [15:0] ts_ff;
   logic        csr_wr;

   // control
   logic [4:0]                state_ff, state_in;
   logic [prp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [prp_pkg::IDX_W-1:0] last_ff, last_in;
   logic [prp_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                      issued_ff, issued_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [23:0]               xi_ff, xi_in, yi_ff, yi_in;
   logic [23:0]               ax_ff, ax_in, ay_ff, ay_in;
   logic                      sx_ff, sx_in, sy_ff, sy_in;
   logic [47:0]               sep_sq_ff, sep_sq_in;
   logic [55:0]               t_ff, t_in;
   logic [48:0]               d2_ff, d2_in;
   logic [23:0]               d_ff, d_in;
   logic [31:0]               f_ff, f_in;
   logic signed [prp_pkg::SUM_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [23:0]               nx_ff, nx_in;
   logic [5:0]                idx_ff, idx_in;
   logic [23:0]               ox_ff, ox_in, oy_ff, oy_in;
   logic                      oa_ff, oa_in, ol_ff, ol_in;

   // memory
   logic [MEM_W-1:0]          mem [0:prp_pkg::MAX_ENTITIES-1];
   logic [MEM_W-1:0]          rd_data_ff;
   logic [prp_pkg::IDX_W-1:0] rd_addr;
   logic                      mem_we;
   logic [prp_pkg::IDX_W-1:0] mem_wa;
   logic [MEM_W-1:0]          mem_wd;

   // unit
   prp_pkg::unit_cmd_type     ucmd;
   prp_pkg::unit_sts_type     usts;
   logic [39:0]               uop_a;
   logic [63:0]               uop_b;
   logic [63:0]               ures;

   // helpers
   logic                      req_xfer;
   logic                      arith_state;
   logic                      adv_i, adv_j;
   logic [24:0]               dx, dy;
   logic [48:0]               d2_sum;
   logic [39:0]               fx_mag, fy_mag;
   logic [31:0]               cq;
   logic [prp_pkg::SUM_W-1:0] c_ext;
   logic [31:0]               disp;
   logic [23:0]               pos_cur, lim_cur;
   logic                      neg_cur;
   logic signed [33:0]        mv;
   logic [23:0]               clamped;

   prp_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ucmd),
      .opnd_a (uop_a),
      .opnd_b (uop_b),
      .sts    (usts),
      .result (ures)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      case (paddr[4:2])
         prp_pkg::REG_SEP_RADIUS: prdata = {8'd0, sep_ff};
         prp_pkg::REG_FORCE_GAIN: prdata = {8'd0, gain_ff};
         prp_pkg::REG_TIME_STEP:  prdata = {16'd0, ts_ff};
         prp_pkg::REG_X_LIMIT:    prdata = {8'd0, width_ff};
         prp_pkg::REG_Y_LIMIT:    prdata = {8'd0, height_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff    <= 24'd2048;
         gain_ff   <= 24'd25600;
         ts_ff     <= 16'd1092;
         width_ff  <= 24'hFFFFFF;
         height_ff <= 24'hFFFFFF;
      end else if (csr_wr) begin
         case (paddr[4:2])
            prp_pkg::REG_SEP_RADIUS: sep_ff    <= pwdata[23:0];
            prp_pkg::REG_FORCE_GAIN: gain_ff   <= pwdata[23:0];
            prp_pkg::REG_TIME_STEP:  ts_ff     <= pwdata[15:0];
            prp_pkg::REG_X_LIMIT:    width_ff  <= pwdata[23:0];
            prp_pkg::REG_Y_LIMIT:    height_ff <= pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // pair geometry from the freshly read body j
   assign dx = {1'b0, xi_ff} - {1'b0, rd_data_ff[23:0]};
   assign dy = {1'b0, yi_ff} - {1'b0, rd_data_ff[47:24]};
   assign d2_sum = {1'b0, t_ff[47:0]} + {1'b0, ures[47:0]};
   assign fx_mag = fx_ff[prp_pkg::SUM_W-1] ? 40'(-fx_ff) : 40'(fx_ff);
   assign fy_mag = fy_ff[prp_pkg::SUM_W-1] ? 40'(-fy_ff) : 40'(fy_ff);
   assign cq     = ures[31:0];
   assign c_ext  = {8'd0, cq};
   assign disp   = ures[55:24];

   // move and clamp, shared by both axes
   always_comb begin
      if (state_ff == S_MVY) begin
         pos_cur = yi_ff;
         lim_cur = height_ff;
         neg_cur = fy_ff[prp_pkg::SUM_W-1];
      end else begin
         pos_cur = xi_ff;
         lim_cur = width_ff;
         neg_cur = fx_ff[prp_pkg::SUM_W-1];
      end
      mv = neg_cur ? $signed({10'd0, pos_cur}) - $signed({2'd0, disp})
                   : $signed({10'd0, pos_cur}) + $signed({2'd0, disp});
      if (mv < 0) begin
         clamped = 24'd0;
      end else if (mv > $signed({10'd0, lim_cur})) begin
         clamped = lim_cur;
      end else begin
         clamped = mv[23:0];
      end
   end

   assign arith_state = (state_ff == S_SQ) || (state_ff == S_MXX) || (state_ff == S_MYY) ||
                        (state_ff == S_SQRT) || (state_ff == S_MP) || (state_ff == S_DF) ||
                        (state_ff == S_MCX) || (state_ff == S_DCX) || (state_ff == S_MCY) ||
                        (state_ff == S_DCY) || (state_ff == S_MVX) || (state_ff == S_MVY);

   // unit operands per state
   always_comb begin
      ucmd.start = arith_state && !issued_ff;
      ucmd.mode  = prp_pkg::MODE_MUL;
      ucmd.count = 6'd24;
      uop_a      = 40'd0;
      uop_b      = 64'd0;
      case (state_ff)
         S_SQ: begin
            uop_a = {16'd0, sep_ff};
            uop_b = {sep_ff, 40'd0};
         end
         S_MXX: begin
            uop_a = {16'd0, ax_ff};
            uop_b = {ax_ff, 40'd0};
         end
         S_MYY: begin
            uop_a = {16'd0, ay_ff};
            uop_b = {ay_ff, 40'd0};
         end
         S_SQRT: begin
            ucmd.mode  = prp_pkg::MODE_SQRT;
            ucmd.count = 6'd25;
            uop_b      = {1'b0, d2_ff, 14'd0};
         end
         S_MP: begin
            uop_a = {16'd0, sep_ff - d_ff};
            uop_b = {gain_ff, 40'd0};
         end
         S_DF: begin
            ucmd.mode  = prp_pkg::MODE_DIV;
            ucmd.count = 6'd32;
            uop_a      = {16'd0, sep_ff};
            uop_b      = {8'd0, t_ff[47:0], 8'd0};
         end
         S_MCX: begin
            uop_a = {8'd0, f_ff};
            uop_b = {ax_ff, 40'd0};
         end
         S_MCY: begin
            uop_a = {8'd0, f_ff};
            uop_b = {ay_ff, 40'd0};
         end
         S_DCX, S_DCY: begin
            ucmd.mode  = prp_pkg::MODE_DIV;
            ucmd.count = 6'd32;
            uop_a      = {16'd0, d_ff};
            uop_b      = {8'd0, t_ff};
         end
         S_MVX: begin
            ucmd.count = 6'd16;
            uop_a      = fx_mag;
            uop_b      = {ts_ff, 48'd0};
         end
         S_MVY: begin
            ucmd.count = 6'd16;
            uop_a      = fy_mag;
            uop_b      = {ts_ff, 48'd0};
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sep_sq_in    = sep_sq_ff;
      t_in         = t_ff;
      d2_in        = d2_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      nx_in        = nx_ff;
      idx_in       = idx_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oa_in        = oa_ff;
      ol_in        = ol_ff;
      adv_i        = 1'b0;
      adv_j        = 1'b0;
      rd_addr      = i_ff;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff[prp_pkg::IDX_W-1:0];
      mem_wd       = {req_body_alive, req_body_y, req_body_x};

      if (ucmd.start) begin
         issued_in = 1'b1;
      end
      if (usts.done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (cnt_ff < prp_pkg::CNT_W'(prp_pkg::MAX_ENTITIES)) begin
                  mem_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  last_in = cnt_ff[prp_pkg::IDX_W-1:0];
               end else begin
                  last_in = prp_pkg::IDX_W'(prp_pkg::MAX_ENTITIES - 1);
               end
               if (req_load_last) begin
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            if (usts.done) begin
               sep_sq_in = ures[47:0];
               i_in      = '0;
               state_in  = S_RDI;
            end
         end
         S_RDI: begin
            rd_addr  = i_ff;
            state_in = S_LDI;
         end
         S_LDI: begin
            xi_in = rd_data_ff[23:0];
            yi_in = rd_data_ff[47:24];
            fx_in = '0;
            fy_in = '0;
            j_in  = '0;
            if (rd_data_ff[48]) begin
               state_in = S_RDJ;
            end else begin
               adv_i = 1'b1;
            end
         end
         S_RDJ: begin
            rd_addr = j_ff;
            if (j_ff == i_ff) begin
               adv_j = 1'b1;
            end else begin
               state_in = S_LDJ;
            end
         end
         S_LDJ: begin
            sx_in = dx[24];
            sy_in = dy[24];
            ax_in = dx[24] ? 24'(-dx) : dx[23:0];
            ay_in = dy[24] ? 24'(-dy) : dy[23:0];
            if (rd_data_ff[48]) begin
               state_in = S_MXX;
            end else begin
               adv_j = 1'b1;
            end
         end
         S_MXX: begin
            if (usts.done) begin
               t_in     = {8'd0, ures[47:0]};
               state_in = S_MYY;
            end
         end
         S_MYY: begin
            if (usts.done) begin
               d2_in = d2_sum;
               // coincident pair or outside the radius
               if (d2_sum == 49'd0 || d2_sum >= {1'b0, sep_sq_ff}) begin
                  adv_j = 1'b1;
               end else begin
                  state_in = S_SQRT;
               end
            end
         end
         S_SQRT: begin
            if (usts.done) begin
               d_in = ures[23:0];
               if (ures[24:0] == 25'd0 || ures[24:0] >= {1'b0, sep_ff}) begin
                  adv_j = 1'b1;
               end else begin
                  state_in = S_MP;
               end
            end
         end
         S_MP: begin
            if (usts.done) begin
               t_in     = {8'd0, ures[47:0]};
               state_in = S_DF;
            end
         end
         S_DF: begin
            if (usts.done) begin
               f_in     = ures[31:0];
               state_in = S_MCX;
            end
         end
         S_MCX: begin
            if (usts.done) begin
               t_in     = ures[55:0];
               state_in = S_DCX;
            end
         end
         S_DCX: begin
            if (usts.done) begin
               fx_in    = sx_ff ? fx_ff - $signed(c_ext) : fx_ff + $signed(c_ext);
               state_in = S_MCY;
            end
         end
         S_MCY: begin
            if (usts.done) begin
               t_in     = ures[55:0];
               state_in = S_DCY;
            end
         end
         S_DCY: begin
            if (usts.done) begin
               fy_in = sy_ff ? fy_ff - $signed(c_ext) : fy_ff + $signed(c_ext);
               adv_j = 1'b1;
            end
         end
         S_MVX: begin
            if (usts.done) begin
               nx_in    = clamped;
               state_in = S_MVY;
            end
         end
         S_MVY: begin
            if (usts.done) begin
               yi_in    = clamped;
               state_in = S_WR;
            end
         end
         S_WR: begin
            mem_we = 1'b1;
            mem_wa = i_ff;
            mem_wd = {1'b1, yi_ff, nx_ff};
            adv_i  = 1'b1;
         end
         S_EMRD: begin
            rd_addr  = k_ff;
            state_in = S_EMLD;
         end
         S_EMLD: begin
            rsp_valid_in = 1'b1;
            idx_in       = k_ff;
            ox_in        = rd_data_ff[23:0];
            oy_in        = rd_data_ff[47:24];
            oa_in        = rd_data_ff[48];
            ol_in        = (k_ff == last_ff);
            state_in     = S_EMOUT;
         end
         S_EMOUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_ff) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv_j) begin
         if (j_ff == last_ff) begin
            state_in = S_MVX;
         end else begin
            j_in     = j_ff + 1'b1;
            state_in = S_RDJ;
         end
      end
      if (adv_i) begin
         if (i_ff == last_ff) begin
            k_in     = '0;
            state_in = S_EMRD;
         end else begin
            i_in     = i_ff + 1'b1;
            state_in = S_RDI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff   <= last_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      xi_ff     <= xi_in;
      yi_ff     <= yi_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      sep_sq_ff <= sep_sq_in;
      t_ff      <= t_in;
      d2_ff     <= d2_in;
      d_ff      <= d_in;
      f_ff      <= f_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      nx_ff     <= nx_in;
      idx_ff    <= idx_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oa_ff     <= oa_in;
      ol_ff     <= ol_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_body_index  = idx_ff;
   assign rsp_new_x       = ox_ff;
   assign rsp_new_y       = oy_ff;
   assign rsp_is_alive    = oa_ff;
   assign rsp_result_last = ol_ff;

   a_unit_done_issued: assert property (@(posedge clock) disable iff (reset)
      usts.done |-> issued_ff)
      else $error("arithmetic unit finished without a pending operation");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= prp_pkg::CNT_W'(prp_pkg::MAX_ENTITIES))
      else $error("loaded count beyond capacity");

   a_no_load_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request taken while results pending");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_result_last) |=> (cnt_ff == '0))
      else $error("loaded count not cleared after final transfer");

endmodule
